[rtl/asob_pkg.sv]
package asob_pkg;

   localparam int MAX_PARTIALS_DEF    = 8;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // Largest quarter-wave table over the supported range of table bits.
   localparam int SINE_TABLE_BITS_MAX = 12;
   localparam int QSINE_ENTRIES       = (1 << (SINE_TABLE_BITS_MAX - 2)) + 1;
   localparam int QSINE_AW            = $clog2(QSINE_ENTRIES);

   localparam int PART_IDX_W = 3;   // partial index, up to eight partials
   localparam int PART_CNT_W = 4;   // partial count register width

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_A    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_B    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_C    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_D    = 3'd6;

   localparam logic [15:0] GAIN_RESET = 16'd4096;

   // pi/2 in Q62
   localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

   typedef logic [15:0] qsine_type [QSINE_ENTRIES];

   typedef struct packed {
      logic                  start;        // new sample: clear accumulator
      logic                  clear_phase;  // restart: zero all phases
      logic                  issue;        // push one partial into the pipe
      logic [PART_IDX_W-1:0] idx;
      logic                  gain;         // apply master gain
      logic                  load_out;     // round, saturate, load output reg
   } cmd_type;

   typedef struct packed {
      logic                  pipe_busy;
      logic                  out_free;
      logic [PART_CNT_W-1:0] count;        // partials in use, clamped
   } stat_type;

   // (a*b) >> s on the full 128-bit product, low 64 bits kept
   function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> s);
   endfunction

   // sine of x in Q62 for 0 <= x <= pi/2, Taylor series
   function automatic logic [63:0] sine_q62(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = mul_shr(x, x, 62);
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
         term = mul_shr(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // quarter-wave table round(32767*sin), evaluated at elaboration
   function automatic qsine_type build_qsine(int tb);
      qsine_type   arr;
      logic [63:0] x;
      logic [63:0] t;
      int          quarter;
      quarter = 1 << (tb - 2);
      for (int j = 0; j < QSINE_ENTRIES; j++) begin
         arr[j] = 16'd0;
         if (j <= quarter) begin
            x      = mul_shr(PI_HALF_Q62, 64'(j), tb - 2);
            t      = mul_shr(sine_q62(x), 64'd65534, 62);
            arr[j] = 16'((t + 64'd1) >> 1);
         end
      end
      return arr;
   endfunction

endpackage

[rtl/asob_ctrl.sv]
module asob_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               restart,
   input  asob_pkg::stat_type stat,
   output asob_pkg::cmd_type  cmd
);
   import asob_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_GAIN  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [PART_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_idx;
   logic                  accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign last_idx   = ((PART_CNT_W'(idx_ff) + PART_CNT_W'(1)) == stat.count);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start       = 1'b1;
               cmd.clear_phase = restart;
               idx_in          = '0;
               state_in        = (stat.count == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + PART_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[rtl/asob_dp.sv]
module asob_dp #(
   parameter int MAX_PARTIALS    = asob_pkg::MAX_PARTIALS_DEF,
   parameter int SINE_TABLE_BITS = asob_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  asob_pkg::cmd_type               cmd,
   output asob_pkg::stat_type              stat,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [asob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asob_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic                            rsp_tuser
);
   import asob_pkg::*;

   localparam int IDX_W   = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int TB      = SINE_TABLE_BITS;
   localparam int QI_W    = TB - 1;             // quarter index incl. endpoint
   localparam int ACC_W   = 35 + $clog2(MAX_PARTIALS + 1);
   localparam int GP_W    = ACC_W + 17;
   localparam int Y_W     = GP_W - 18;
   localparam logic [QI_W-1:0] QUARTER = QI_W'(1 << (TB - 2));
   localparam logic signed [Y_W-1:0] Y_HI = Y_W'(OUT_MAX);
   localparam logic signed [Y_W-1:0] Y_LO = Y_W'(OUT_MIN);
   localparam logic signed [GP_W-1:0] ROUND_HALF = GP_W'(1 << 17);
   localparam qsine_type QSINE = build_qsine(TB);

   // configuration
   logic [31:0]           base_ff;
   logic [15:0]           gain_ff;
   logic [PART_CNT_W-1:0] pcount_ff;
   logic [63:0]           preg_ff [4];

   // phase accumulators
   logic [31:0]           phase_ff [MAX_PARTIALS];

   // stage 0 lookup
   logic [63:0]           preg_sel;
   logic [31:0]           word;
   logic [31:0]           phase_rd;
   logic [TB-1:0]         k;
   logic [TB-3:0]         j;
   logic [QI_W-1:0]       qidx;
   logic [47:0]           step_prod;

   // stage 1
   logic                  v_s1_ff;
   logic [IDX_W-1:0]      idx_s1_ff;
   logic [31:0]           phase_s1_ff;
   logic [31:0]           step_s1_ff;
   logic [15:0]           amp_s1_ff;
   logic [15:0]           qsine_s1_ff;
   logic                  neg_s1_ff;
   logic signed [16:0]    amp_sg;
   logic signed [16:0]    sine_sg;
   logic signed [33:0]    prod_in;

   // stage 2 and back end
   logic                  v_s2_ff;
   logic signed [33:0]    prod_s2_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [GP_W-1:0]  gp_ff, gp_in;
   logic signed [GP_W-1:0]  rnd;
   logic signed [Y_W-1:0]   y;
   logic [23:0]           sample_in;
   logic                  clip_in;

   logic                  out_valid_ff, out_valid_in;
   logic [23:0]           sample_ff;
   logic                  clip_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         gain_ff   <= GAIN_RESET;
         pcount_ff <= '0;
         for (int r = 0; r < 4; r++) begin
            preg_ff[r] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_STEP: base_ff    <= csr_data[31:0];
            CSR_GAIN:      gain_ff    <= csr_data[15:0];
            CSR_COUNT:     pcount_ff  <= csr_data[PART_CNT_W-1:0];
            CSR_PART_A:    preg_ff[0] <= csr_data;
            CSR_PART_B:    preg_ff[1] <= csr_data;
            CSR_PART_C:    preg_ff[2] <= csr_data;
            CSR_PART_D:    preg_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   assign stat.count     = (pcount_ff > PART_CNT_W'(MAX_PARTIALS)) ?
                           PART_CNT_W'(MAX_PARTIALS) : pcount_ff;
   assign stat.pipe_busy = v_s1_ff | v_s2_ff;
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   // stage 0: fetch phase and partial word, table address, phase step
   always_comb begin
      preg_sel  = preg_ff[cmd.idx[2:1]];
      word      = cmd.idx[0] ? preg_sel[63:32] : preg_sel[31:0];
      phase_rd  = phase_ff[cmd.idx[IDX_W-1:0]];
      k         = phase_rd[31 -: TB];
      j         = k[TB-3:0];
      qidx      = k[TB-2] ? (QUARTER - {1'b0, j}) : {1'b0, j};
      step_prod = 48'(base_ff) * 48'(word[31:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s1_ff <= 1'b0;
      end else begin
         v_s1_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      idx_s1_ff   <= cmd.idx[IDX_W-1:0];
      phase_s1_ff <= phase_rd;
      step_s1_ff  <= step_prod[39:8];
      amp_s1_ff   <= word[15:0];
      qsine_s1_ff <= QSINE[QSINE_AW'(qidx)];
      neg_s1_ff   <= k[TB-1];
   end

   // stage 1: signed sine, amplitude product, phase advance
   assign amp_sg  = $signed({1'b0, amp_s1_ff});
   assign sine_sg = neg_s1_ff ? -$signed({1'b0, qsine_s1_ff}) : $signed({1'b0, qsine_s1_ff});
   assign prod_in = amp_sg * sine_sg;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_PARTIALS; p++) begin
            phase_ff[p] <= '0;
         end
      end else if (cmd.clear_phase) begin
         for (int p = 0; p < MAX_PARTIALS; p++) begin
            phase_ff[p] <= '0;
         end
      end else if (v_s1_ff) begin
         phase_ff[idx_s1_ff] <= phase_s1_ff + step_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s2_ff <= 1'b0;
      end else begin
         v_s2_ff <= v_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_s2_ff <= prod_in;
   end

   // stage 2: accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.start) begin
         acc_ff <= '0;
      end else if (v_s2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_s2_ff);
      end
   end

   // master gain
   assign gp_in = acc_ff * $signed({1'b0, gain_ff});

   always_ff @(posedge clock) begin
      if (cmd.gain) begin
         gp_ff <= gp_in;
      end
   end

   // round half up, floor shift, saturate
   always_comb begin
      rnd       = gp_ff + ROUND_HALF;
      y         = rnd[GP_W-1:18];
      sample_in = y[23:0];
      clip_in   = 1'b0;
      if (y > Y_HI) begin
         sample_in = 24'h7FFFFF;
         clip_in   = 1'b1;
      end else if (y < Y_LO) begin
         sample_in = 24'h800000;
         clip_in   = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         sample_ff <= sample_in;
         clip_ff   <= clip_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = sample_ff;
   assign rsp_tuser  = clip_ff;

endmodule

[rtl/additive_sine_oscillator_bank.sv]
// Additive sine oscillator bank: one signed 24-bit audio sample per request beat.
// req_*: one beat per sample tick; req_tdata[0] = restart (zero all phases first).
// rsp_*: one beat per request, in order; rsp_tdata = sample, rsp_tuser = clipped.
// csr_*: register writes (index 0 base step, 1 master gain, 2 partial count,
//   3..6 partial pairs); csr_ready is always high. Write only while idle.
// Sample = sum of amp * sine(phase) over the partials in use, times master
//   gain (Q4.12), rounded half up at bit 18 and saturated to 24 bits.
// Partials run one per cycle through a three-stage pipe (table read and
//   phase step multiply, amplitude multiply and phase advance, accumulate).
// A request beat starts the sequence: one partial per cycle through the
//   pipe (count clamped to MAX_PARTIALS), pipe drain, then the gain and
//   saturate steps and the output load; with no partials in use the
//   pipe is skipped. The next request is taken only once the output
//   register is loaded, so one sample is done before the next starts.
// The output register decouples the sides: a new request is taken while a
//   result waits; if the receiver still stalls, the block waits to load.
// Reset: phases zero, master gain 4096, other CSR registers zero, no beat pending.
module additive_sine_oscillator_bank #(
   parameter int MAX_PARTIALS    = asob_pkg::MAX_PARTIALS_DEF,
   parameter int SINE_TABLE_BITS = asob_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [0] restart, [7:1] zero
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [23:0] sample (signed)
   output logic                            rsp_tuser,   // [0] clipped
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [asob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asob_pkg::CSR_DATA_W-1:0] csr_data
);
   import asob_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks the partials, then drain, gain, output load
   asob_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .stat       (stat),
      .cmd        (cmd)
   );

   // registers, phase accumulators, sine table, MAC and output stage
   asob_dp #(
      .MAX_PARTIALS    (MAX_PARTIALS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // a clipped beat carries a rail value
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 24'h7FFFFF || rsp_tdata == 24'h800000))
      else $error("clipped beat not at a rail");

   // output is loaded only after all partials have left the pipe
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !stat.pipe_busy)
      else $error("output loaded with partials in flight");

   // only partials in use enter the pipe
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (PART_CNT_W'(cmd.idx) < stat.count))
      else $error("partial issued beyond count");

   // no new sample starts while partials are in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !stat.pipe_busy)
      else $error("sample started with pipe busy");
`endif

endmodule

[tb/tb.sv]
module tb;
   import asob_pkg::*;

   localparam int TBL_BITS     = SINE_TABLE_BITS_DEF;
   localparam int QW_LEN       = 1 << (TBL_BITS - 2);
   localparam int PARTIALS     = MAX_PARTIALS_DEF;
   localparam int TOTAL_ITEMS  = 1150;
   // drain for twice the length of the slowest sample
   localparam int DRAIN_CYCLES = 2 * (PARTIALS + 6);
   // Longest quiet stretch in a correct run: a sender gap plus one full
   // sample plus a receiver stall run.
   localparam int HANG_LIMIT   = 2000;

   // index past the register map; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [23:0] sample;
      logic        clipped;
   } tone_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_TOGGLE} sink_mode_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   additive_sine_oscillator_bank u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Oscillator model: register copy, phase accumulators, sine ROM
   // ---------------------------------------------------------------
   logic [31:0] cfg_step  = 32'd0;
   logic [15:0] cfg_gain  = GAIN_RESET;
   logic [3:0]  cfg_count = 4'd0;
   logic [63:0] cfg_pairs [4] = '{default: 64'd0};
   logic [31:0] osc_phase [PARTIALS] = '{default: 32'd0};
   int          quarter_wave [0:QW_LEN];

   logic     pending_restarts [$];   // request beats not yet on the bus
   tone_type expected_tones [$];     // predicted samples, oldest first
   int       items_queued = 0;
   int       results_seen = 0;
   int       n_errors     = 0;

   // (a*b) >> s, low 64 bits of the shifted 128-bit product
   function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[s +: 64];
   endfunction

   // sin(x), x and result in Q62, first quadrant; 13 series terms
   function automatic logic [63:0] taylor_sin_q62(logic [63:0] x);
      logic [63:0] xx;
      logic [63:0] term;
      logic [63:0] acc;
      xx   = prod_shift(x, x, 62);
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
         term = prod_shift(term, xx, 62) / 64'(2 * n * (2 * n + 1));
         acc  = (n % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   // full-wave sine from the quarter table, top TBL_BITS of the phase
   function automatic int wave_at(logic [31:0] ph);
      logic [TBL_BITS-1:0] k;
      logic [1:0]          quad;
      int                  j;
      int                  v;
      k    = ph[31 -: TBL_BITS];
      quad = k[TBL_BITS-1 -: 2];
      j    = int'(k[TBL_BITS-3:0]);
      v    = quad[0] ? quarter_wave[QW_LEN - j] : quarter_wave[j];
      return quad[1] ? -v : v;
   endfunction

   // one tick: sum the partials in use, gain, round, saturate; advance phases
   function automatic void predict_tone(logic restart);
      tone_type    want;
      longint      acc;
      longint      t;
      longint      y;
      int          n;
      logic [31:0] word;
      logic [63:0] prod;
      if (restart) begin
         foreach (osc_phase[i]) osc_phase[i] = 32'd0;
      end
      // counts above the bank size act as a full bank
      n   = (cfg_count > PARTIALS) ? PARTIALS : int'(cfg_count);
      acc = 0;
      for (int i = 0; i < n; i++) begin
         word = 32'(cfg_pairs[i >> 1] >> (32 * (i & 1)));
         acc += longint'({48'd0, word[15:0]}) * longint'(wave_at(osc_phase[i]));
         prod = 64'(cfg_step) * 64'(word[31:16]);
         // step truncates to 32 bits, phase wraps
         osc_phase[i] += prod[39:8];
      end
      t = acc * longint'({48'd0, cfg_gain}) + 64'sd131072;
      y = t >>> 18;   // floor: half rounds up
      want.clipped = 1'b0;
      if (y > OUT_MAX) begin
         y = OUT_MAX;
         want.clipped = 1'b1;
      end else if (y < OUT_MIN) begin
         y = OUT_MIN;
         want.clipped = 1'b1;
      end
      want.sample = y[23:0];
      expected_tones.push_back(want);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: bursts of beats separated by random gaps
   // ---------------------------------------------------------------
   int         burst_left;
   int         gap_left;
   logic       next_valid;
   logic [7:0] next_data;

   always @(posedge clock) begin : drive_p
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         // the held beat is taken at this edge, or the bus is empty
         if (req_tvalid) begin
            predict_tone(req_tdata[0]);
         end
         next_valid = 1'b0;
         next_data  = req_tdata;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_restarts.size() != 0) begin
            next_valid = 1'b1;
            next_data  = {7'd0, pending_restarts.pop_front()};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
      end
   end

   // ---------------------------------------------------------------
   // Result checker and receiver stall pattern
   // ---------------------------------------------------------------
   sink_mode_type sink_mode;
   int            mode_left;
   logic          ready_next;
   tone_type      got;

   always @(posedge clock) begin : sink_p
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_mode = SINK_OPEN;
         mode_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_tones.size() == 0) begin
               $display("%0t: unexpected result beat: sample %0d clipped %0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               n_errors++;
            end else begin
               got = expected_tones.pop_front();
               if (rsp_tdata !== got.sample) begin
                  $display("%0t: sample mismatch: expected %0d actual %0d",
                           $time, $signed(got.sample), $signed(rsp_tdata));
                  n_errors++;
               end
               if (rsp_tuser !== got.clipped) begin
                  $display("%0t: clipped mismatch: expected %0b actual %0b",
                           $time, got.clipped, rsp_tuser);
                  n_errors++;
               end
            end
         end
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(30, 300);
         end else begin
            mode_left--;
         end
         case (sink_mode)
            SINK_OPEN:   ready_next = 1'b1;
            SINK_HALF:   ready_next = $urandom_range(0, 1) == 1;
            SINK_SPARSE: ready_next = $urandom_range(0, 3) == 0;
            default:     ready_next = ~rsp_tready;
         endcase
         rsp_tready <= ready_next;
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: no beat on any channel for too long ends the run
   // ---------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog_p
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Register writes and stimulus
   // ---------------------------------------------------------------

   // csr_valid stays high after the beat; the caller lowers it after a batch
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      case (idx)
         CSR_BASE_STEP: cfg_step  = val[31:0];
         CSR_GAIN:      cfg_gain  = val[15:0];
         CSR_COUNT:     cfg_count = val[3:0];
         CSR_PART_A, CSR_PART_B, CSR_PART_C, CSR_PART_D:
            cfg_pairs[2'(idx - CSR_PART_A)] = val;
         default: ;   // unmapped, dropped
      endcase
   endtask

   task automatic wait_idle();
      while (items_queued != results_seen) @(posedge clock);
   endtask

   task automatic add_item(input logic restart);
      pending_restarts.push_back(restart);
      items_queued++;
   endtask

   function automatic logic [63:0] rand_step();
      logic [31:0] s;
      case ($urandom_range(0, 5))
         0:       s = 32'd0;
         1:       s = 32'hFFFF_FFFF;
         2, 3:    s = 32'($urandom_range(0, 32'h0400_0000));   // audio range
         default: s = $urandom;
      endcase
      return {$urandom, s};
   endfunction

   function automatic logic [63:0] rand_gain();
      logic [15:0] g;
      case ($urandom_range(0, 4))
         0:       g = GAIN_RESET;
         1:       g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2:       g = 16'($urandom_range(0, 4096));
         default: g = 16'($urandom);
      endcase
      return {$urandom, 16'($urandom), g};
   endfunction

   // Q8.8 ratio high, Q2.14 amplitude low
   function automatic logic [31:0] rand_partial();
      logic [15:0] ratio;
      logic [15:0] amp;
      case ($urandom_range(0, 3))
         0:       ratio = 16'($urandom_range(1, 8)) << 8;   // harmonic
         1:       ratio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: ratio = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       amp = 16'($urandom_range(0, 16'h0800));
         1:       amp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: amp = 16'($urandom);
      endcase
      return {ratio, amp};
   endfunction

   initial begin : stim_p
      logic [63:0] x;
      logic [63:0] s;
      int          n;

      for (int j = 0; j <= QW_LEN; j++) begin
         x = prod_shift(PI_HALF_Q62, 64'(j), TBL_BITS - 2);
         s = prod_shift(taylor_sin_q62(x), 64'd65534, 62);
         quarter_wave[j] = int'((s + 64'd1) >> 1);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset registers: no partials, sample 0 whatever the restart bit;
      // a write past the map must change nothing
      write_reg(CSR_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_valid <= 1'b0;
      add_item(1'b0);
      add_item(1'b1);
      add_item(1'b0);

      // quarter-turn steps, full amplitude and gain on all eight partials:
      // phases walk 0, +peak, 0, -peak, so both saturation limits are hit
      wait_idle();
      write_reg(CSR_BASE_STEP, {32'hDEAD_BEEF, 32'h4000_0000});
      write_reg(CSR_GAIN, 64'h0000_0000_0000_FFFF);
      write_reg(CSR_COUNT, 64'd8);
      write_reg(CSR_PART_A, {2{16'h0100, 16'hFFFF}});
      write_reg(CSR_PART_B, {2{16'h0100, 16'hFFFF}});
      write_reg(CSR_PART_C, {2{16'h0100, 16'hFFFF}});
      write_reg(CSR_PART_D, {2{16'h0100, 16'hFFFF}});
      csr_valid <= 1'b0;
      add_item(1'b1);
      repeat (4) add_item(1'b0);

      // largest step times largest ratio overflows 32 bits; a zero ratio
      // freezes its partial; count 15 must act as eight
      wait_idle();
      write_reg(CSR_BASE_STEP, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_GAIN, {48'd0, GAIN_RESET});
      write_reg(CSR_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_PART_A, {16'h0000, 16'h4000, 16'hFFFF, 16'h4000});
      write_reg(CSR_PART_D, {16'hFFFF, 16'h0000, 16'h8000, 16'h2000});
      csr_valid <= 1'b0;
      add_item(1'b1);
      repeat (4) add_item(1'b0);

      // shrink to two partials: the rest must hold their phases ...
      wait_idle();
      write_reg(CSR_COUNT, 64'd2);
      csr_valid <= 1'b0;
      repeat (3) add_item(1'b0);

      // ... and pick up from there once back in use
      wait_idle();
      write_reg(CSR_COUNT, 64'd8);
      csr_valid <= 1'b0;
      repeat (3) add_item(1'b0);

      // empty bank with a restart
      wait_idle();
      write_reg(CSR_COUNT, 64'd0);
      csr_valid <= 1'b0;
      add_item(1'b1);
      add_item(1'b0);

      // random phases; registers left alone keep running phases, so a
      // step change without restart must not jump them
      while (items_queued < TOTAL_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 4) != 0) write_reg(CSR_BASE_STEP, rand_step());
         if ($urandom_range(0, 2) == 0) write_reg(CSR_GAIN, rand_gain());
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_COUNT, {$urandom, 28'($urandom),
                                  ($urandom_range(0, 4) == 0) ?
                                  4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8))});
         end
         for (int r = 0; r < 4; r++) begin
            if ($urandom_range(0, 1) == 1) begin
               write_reg(CSR_PART_A + 3'(r), {rand_partial(), rand_partial()});
            end
         end
         if ($urandom_range(0, 15) == 0) write_reg(CSR_UNMAPPED, {$urandom, $urandom});
         csr_valid <= 1'b0;
         n = $urandom_range(20, 90);
         repeat (n) add_item($urandom_range(0, 15) == 0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0 && expected_tones.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
